@@ hdl/vertex_view_transform_project_assert.svh @@
// Assertion macros for the vertex transform RTL.
`ifndef VERTEX_VIEW_TRANSFORM_PROJECT_ASSERT_SVH
`define VERTEX_VIEW_TRANSFORM_PROJECT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define VVT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define VVT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/vvt_pkg.sv @@
// Shared constants and types for the vertex view transform.
package vvt_pkg;

    localparam int NUM_W = 48;   // magnitude of a projection numerator
    localparam int DEN_W = 30;   // positive view depth
    localparam int QW    = 17;   // quotient bits kept before saturation

    localparam logic signed [16:0] SCREEN_CENTER_X = 17'sd400;
    localparam logic signed [16:0] SCREEN_CENTER_Y = 17'sd300;

    localparam logic [15:0] COORD_MAX = 16'h7fff;
    localparam logic [15:0] COORD_MIN = 16'h8000;
    localparam logic [23:0] DEPTH_MAX = 24'h7fffff;
    localparam logic [23:0] DEPTH_MIN = 24'h800000;

    typedef enum logic [2:0] {
        REG_CAM_X  = 3'd0,
        REG_CAM_Y  = 3'd1,
        REG_CAM_Z  = 3'd2,
        REG_ZX_COS = 3'd3,
        REG_ZX_SIN = 3'd4,
        REG_ZY_COS = 3'd5,
        REG_ZY_SIN = 3'd6,
        REG_FOCAL  = 3'd7
    } reg_index_t;

    // Per-vertex values that ride alongside the divider.
    typedef struct packed {
        logic [23:0] dz;
        logic        behind;
        logic        dz_clip;
        logic        last;
        logic        neg_x;
        logic        neg_y;
    } side_t;

endpackage

@@ hdl/vertex_view_transform_project.sv @@
// Top level of the vertex view transform and perspective projection pipeline.
//
//  Channel   Direction  Handshake                       Content
//  cfg       in         cfg_we                          cfg_index, cfg_data (register write)
//  s_axis    in         s_axis_tvalid / s_axis_tready   model vertex, tlast = last_in
//  m_axis    out        m_axis_tvalid / m_axis_tready   screen coordinates, depth, flags
//
//  One vertex enters per cycle unless the output stalls; eight arithmetic stages feed an
//  18-stage divider (input register, then one quotient bit per stage), then one output register.
//  Every stage moves on one shared enable, so a stall at the output freezes the
//  whole pipeline and s_axis_tready falls with it.
//  Reset clears the valid bits and loads the register defaults; no clearing pass.
module vertex_view_transform_project
    import vvt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // vertex_x, vertex_y, vertex_z
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // screen_x, screen_y, depth_z, behind_camera, clipped, pad
    output logic        m_axis_tlast
);

    `include "vertex_view_transform_project_assert.svh"

    function automatic logic [16:0] fin_coord(input logic [QW-1:0] mag, input logic neg,
                                              input logic ovf);
        logic [15:0] val;
        logic        clip;
        clip = 1'b0;
        val  = mag[15:0];
        if (ovf)
        begin
            clip = 1'b1;
            val  = neg ? COORD_MIN : COORD_MAX;
        end
        else if (neg)
        begin
            if (mag > 17'd32768)
            begin
                clip = 1'b1;
                val  = COORD_MIN;
            end
            else
                val = 16'(~mag + 17'd1);
        end
        else if (mag > 17'd32767)
        begin
            clip = 1'b1;
            val  = COORD_MAX;
        end
        return {clip, val};
    endfunction

    logic signed [23:0] cam_x_reg, cam_y_reg, cam_z_reg;
    logic signed [15:0] zx_cos_reg, zx_sin_reg, zy_cos_reg, zy_sin_reg;
    logic        [15:0] focal_reg;

    logic en;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg, v8_reg;
    logic l1_reg, l2_reg, l3_reg, l4_reg, l5_reg;

    logic signed [24:0] tx1_reg, ty1_reg, tz1_reg;
    logic signed [40:0] p_c1tx2_reg, p_s1tz2_reg, p_s1tx2_reg, p_c1tz2_reg;
    logic signed [24:0] ty2_reg, ty3_reg;
    logic signed [27:0] xr3_reg, zt3_reg, xr4_reg, xr5_reg;
    logic signed [40:0] p_c2ty4_reg, p_s2ty4_reg;
    logic signed [43:0] p_s2zt4_reg, p_c2zt4_reg;
    logic signed [30:0] yr5_reg, zr5_reg, zr6_reg, zr7_reg;
    logic signed [44:0] pfx6_reg;
    logic signed [47:0] pfy6_reg, pcx6_reg, pcy6_reg;
    logic signed [48:0] nx7_reg, ny7_reg;
    side_t              side6_reg, side7_reg, side8_reg;
    logic [NUM_W-1:0]   magx8_reg, magy8_reg;
    logic [DEN_W-1:0]   den8_reg;

    logic signed [41:0] sum_x3, sum_z3;
    logic signed [44:0] sum_y5, sum_z5;
    logic signed [16:0] focal_s;
    logic               behind5;

    logic               div_valid, div_ovf_x, div_ovf_y;
    side_t              div_side;
    logic [QW-1:0]      div_qx, div_qy;
    logic [16:0]        cx, cy;

    logic               out_valid_reg, out_last_reg, out_behind_reg, out_clip_reg;
    logic [15:0]        out_sx_reg, out_sy_reg;
    logic [23:0]        out_dz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cam_x_reg  <= '0;
            cam_y_reg  <= '0;
            cam_z_reg  <= '0;
            zx_cos_reg <= 16'sd16384;
            zx_sin_reg <= '0;
            zy_cos_reg <= 16'sd16384;
            zy_sin_reg <= '0;
            focal_reg  <= 16'd1000;
        end
        else if (cfg_we)
        begin
            case (reg_index_t'(cfg_index))
                REG_CAM_X:  cam_x_reg  <= cfg_data;
                REG_CAM_Y:  cam_y_reg  <= cfg_data;
                REG_CAM_Z:  cam_z_reg  <= cfg_data;
                REG_ZX_COS: zx_cos_reg <= cfg_data[15:0];
                REG_ZX_SIN: zx_sin_reg <= cfg_data[15:0];
                REG_ZY_COS: zy_cos_reg <= cfg_data[15:0];
                REG_ZY_SIN: zy_sin_reg <= cfg_data[15:0];
                REG_FOCAL:  focal_reg  <= cfg_data[15:0];
                default:    ;
            endcase
        end
    end

    assign en            = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0; v2_reg <= 1'b0; v3_reg <= 1'b0; v4_reg <= 1'b0;
            v5_reg <= 1'b0; v6_reg <= 1'b0; v7_reg <= 1'b0; v8_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= s_axis_tvalid;
            v2_reg <= v1_reg; v3_reg <= v2_reg; v4_reg <= v3_reg;
            v5_reg <= v4_reg; v6_reg <= v5_reg; v7_reg <= v6_reg; v8_reg <= v7_reg;
        end
    end

    // Floor division by 2^14 is the arithmetic shift, taken here as a part-select.
    assign sum_x3  = {p_c1tx2_reg[40], p_c1tx2_reg} - {p_s1tz2_reg[40], p_s1tz2_reg};
    assign sum_z3  = {p_s1tx2_reg[40], p_s1tx2_reg} + {p_c1tz2_reg[40], p_c1tz2_reg};
    assign sum_y5  = {{4{p_c2ty4_reg[40]}}, p_c2ty4_reg} - {p_s2zt4_reg[43], p_s2zt4_reg};
    assign sum_z5  = {{4{p_s2ty4_reg[40]}}, p_s2ty4_reg} + {p_c2zt4_reg[43], p_c2zt4_reg};
    assign focal_s = {1'b0, focal_reg};
    assign behind5 = zr5_reg[30] || (zr5_reg == '0);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tx1_reg <= {s_axis_tdata[23], s_axis_tdata[23:0]}  - {cam_x_reg[23], cam_x_reg};
            ty1_reg <= {s_axis_tdata[47], s_axis_tdata[47:24]} - {cam_y_reg[23], cam_y_reg};
            tz1_reg <= {s_axis_tdata[71], s_axis_tdata[71:48]} - {cam_z_reg[23], cam_z_reg};
            l1_reg  <= s_axis_tlast;

            p_c1tx2_reg <= zx_cos_reg * tx1_reg;
            p_s1tz2_reg <= zx_sin_reg * tz1_reg;
            p_s1tx2_reg <= zx_sin_reg * tx1_reg;
            p_c1tz2_reg <= zx_cos_reg * tz1_reg;
            ty2_reg     <= ty1_reg;
            l2_reg      <= l1_reg;

            xr3_reg <= sum_x3[41:14];
            zt3_reg <= sum_z3[41:14];
            ty3_reg <= ty2_reg;
            l3_reg  <= l2_reg;

            p_c2ty4_reg <= zy_cos_reg * ty3_reg;
            p_s2ty4_reg <= zy_sin_reg * ty3_reg;
            p_s2zt4_reg <= zy_sin_reg * zt3_reg;
            p_c2zt4_reg <= zy_cos_reg * zt3_reg;
            xr4_reg     <= xr3_reg;
            l4_reg      <= l3_reg;

            yr5_reg <= sum_y5[44:14];
            zr5_reg <= sum_z5[44:14];
            xr5_reg <= xr4_reg;
            l5_reg  <= l4_reg;

            pfx6_reg <= xr5_reg * focal_s;
            pfy6_reg <= yr5_reg * focal_s;
            pcx6_reg <= zr5_reg * SCREEN_CENTER_X;
            pcy6_reg <= zr5_reg * SCREEN_CENTER_Y;
            zr6_reg  <= zr5_reg;
            side6_reg.behind <= behind5;
            // Depth fits 24 bits when the bits above the sign all match it.
            if (zr5_reg[30:23] != {8{zr5_reg[23]}})
            begin
                side6_reg.dz_clip <= 1'b1;
                side6_reg.dz      <= zr5_reg[30] ? DEPTH_MIN : DEPTH_MAX;
            end
            else
            begin
                side6_reg.dz_clip <= 1'b0;
                side6_reg.dz      <= zr5_reg[23:0];
            end
            side6_reg.last  <= l5_reg;
            side6_reg.neg_x <= 1'b0;
            side6_reg.neg_y <= 1'b0;

            nx7_reg   <= {{4{pfx6_reg[44]}}, pfx6_reg} + {pcx6_reg[47], pcx6_reg};
            ny7_reg   <= {pfy6_reg[47], pfy6_reg} + {pcy6_reg[47], pcy6_reg};
            zr7_reg   <= zr6_reg;
            side7_reg <= side6_reg;

            magx8_reg         <= nx7_reg[48] ? NUM_W'(-nx7_reg) : NUM_W'(nx7_reg);
            magy8_reg         <= ny7_reg[48] ? NUM_W'(-ny7_reg) : NUM_W'(ny7_reg);
            den8_reg          <= side7_reg.behind ? DEN_W'(1) : zr7_reg[DEN_W-1:0];
            side8_reg.dz      <= side7_reg.dz;
            side8_reg.behind  <= side7_reg.behind;
            side8_reg.dz_clip <= side7_reg.dz_clip;
            side8_reg.last    <= side7_reg.last;
            side8_reg.neg_x   <= nx7_reg[48];
            side8_reg.neg_y   <= ny7_reg[48];
        end
    end

    vvt_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v8_reg),
        .in_side   (side8_reg),
        .num_x     (magx8_reg),
        .num_y     (magy8_reg),
        .den       (den8_reg),
        .out_valid (div_valid),
        .out_side  (div_side),
        .q_x       (div_qx),
        .q_y       (div_qy),
        .ovf_x     (div_ovf_x),
        .ovf_y     (div_ovf_y)
    );

    assign cx = fin_coord(div_qx, div_side.neg_x, div_ovf_x);
    assign cy = fin_coord(div_qy, div_side.neg_y, div_ovf_y);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= div_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_sx_reg     <= div_side.behind ? 16'd0 : cx[15:0];
            out_sy_reg     <= div_side.behind ? 16'd0 : cy[15:0];
            out_dz_reg     <= div_side.dz;
            out_behind_reg <= div_side.behind;
            out_clip_reg   <= div_side.dz_clip || (!div_side.behind && (cx[16] || cy[16]));
            out_last_reg   <= div_side.last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_clip_reg, out_behind_reg, out_dz_reg, out_sy_reg,
                            out_sx_reg};
    assign m_axis_tlast  = out_last_reg;

    `VVT_ASSERT_NOW(a_behind_zero, out_valid_reg && out_behind_reg,
        out_sx_reg == 16'd0 && out_sy_reg == 16'd0, "behind vertex has nonzero coordinates")

    `VVT_ASSERT_NOW(a_clip_source,
        out_valid_reg && out_clip_reg && out_dz_reg != DEPTH_MAX && out_dz_reg != DEPTH_MIN,
        out_sx_reg == COORD_MAX || out_sx_reg == COORD_MIN ||
        out_sy_reg == COORD_MAX || out_sy_reg == COORD_MIN,
        "clip flag set without a saturated value")

    `VVT_ASSERT_NOW(a_empty_accepts, !out_valid_reg, s_axis_tready,
        "input refused while output register is empty")

    `VVT_ASSERT_NOW(a_div_feed, v8_reg && side8_reg.behind,
        den8_reg == DEN_W'(1), "behind vertex reached divider with a bad divisor")

endmodule

@@ hdl/vvt_div.sv @@
// Two-lane pipelined restoring divider with a shared divisor, one quotient bit per stage.
module vvt_div
    import vvt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  side_t            in_side,
    input  logic [NUM_W-1:0] num_x,
    input  logic [NUM_W-1:0] num_y,
    input  logic [DEN_W-1:0] den,
    output logic             out_valid,
    output side_t            out_side,
    output logic [QW-1:0]    q_x,
    output logic [QW-1:0]    q_y,
    output logic             ovf_x,
    output logic             ovf_y
);

    logic             valid_reg [0:QW];
    side_t            side_reg  [0:QW];
    logic [NUM_W-1:0] rem_x_reg [0:QW];
    logic [NUM_W-1:0] rem_y_reg [0:QW];
    logic [QW-1:0]    q_x_reg   [0:QW];
    logic [QW-1:0]    q_y_reg   [0:QW];
    logic [DEN_W-1:0] den_reg   [0:QW];
    logic             ovf_x_reg [0:QW];
    logic             ovf_y_reg [0:QW];

    logic [NUM_W-1:0] den_top;

    // A quotient of 2^QW or more can only saturate, so it is flagged up front.
    assign den_top = {1'b0, den, {QW{1'b0}}};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg[0] <= 1'b0;
        else if (en)
            valid_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0]  <= in_side;
            rem_x_reg[0] <= num_x;
            rem_y_reg[0] <= num_y;
            q_x_reg[0]   <= '0;
            q_y_reg[0]   <= '0;
            den_reg[0]   <= den;
            ovf_x_reg[0] <= (num_x >= den_top);
            ovf_y_reg[0] <= (num_y >= den_top);
        end
    end

    for (genvar k = 1; k <= QW; k++)
    begin : g_stage
        localparam int B = QW - k;
        logic [NUM_W-1:0] trial;
        logic             ge_x;
        logic             ge_y;

        assign trial = NUM_W'(den_reg[k-1]) << B;
        assign ge_x  = (rem_x_reg[k-1] >= trial);
        assign ge_y  = (rem_y_reg[k-1] >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (en)
                valid_reg[k] <= valid_reg[k-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[k]  <= side_reg[k-1];
                rem_x_reg[k] <= ge_x ? rem_x_reg[k-1] - trial : rem_x_reg[k-1];
                rem_y_reg[k] <= ge_y ? rem_y_reg[k-1] - trial : rem_y_reg[k-1];
                q_x_reg[k]   <= q_x_reg[k-1] | (QW'(ge_x) << B);
                q_y_reg[k]   <= q_y_reg[k-1] | (QW'(ge_y) << B);
                den_reg[k]   <= den_reg[k-1];
                ovf_x_reg[k] <= ovf_x_reg[k-1];
                ovf_y_reg[k] <= ovf_y_reg[k-1];
            end
        end
    end

    assign out_valid = valid_reg[QW];
    assign out_side  = side_reg[QW];
    assign q_x       = q_x_reg[QW];
    assign q_y       = q_y_reg[QW];
    assign ovf_x     = ovf_x_reg[QW];
    assign ovf_y     = ovf_y_reg[QW];

endmodule

@@ tb/sv/vertex_view_transform_project_tb.sv @@
// Self-checking testbench for the vertex view transform and projection block.
`timescale 1ns / 1ps

module vertex_view_transform_project_tb;
    import vvt_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [23:0] cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;     // vertex_x, vertex_y, vertex_z
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;     // screen_x, screen_y, depth_z, behind_camera, clipped, pad
    logic        m_axis_tlast;

    vertex_view_transform_project dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
    );

    typedef struct packed {
        logic [15:0] screen_x;
        logic [15:0] screen_y;
        logic [23:0] depth_z;
        logic        behind;
        logic        clipped;
        logic        last;
    } pixel_t;

    typedef struct {
        logic [23:0] vx;
        logic [23:0] vy;
        logic [23:0] vz;
        logic        last;
        bit          typed;    // row carries a hand-written expectation
        pixel_t      want;
    } vertex_row_t;

    // Shadow copy of the block's registers.
    logic signed [23:0] cam_x, cam_y, cam_z;
    logic signed [15:0] rot1_cos, rot1_sin, rot2_cos, rot2_sin;
    logic [15:0]        focal;

    pixel_t      pending_pixels[$];
    vertex_row_t directed_rows[$];
    int          error_count;
    int          sent_count;
    int          recv_count;
    int          behind_count;
    int          clip_count;
    int          send_idle_pct;
    int          recv_stall_pct;

    initial clk = 1'b0;
    always #6 clk = ~clk;

    initial
    begin
        #200ms;
        $display("FAIL vertex_view_transform_project");
        $finish;
    end

    function automatic longint floor_shift14(longint v);
        if (v >= 0)
            return v >>> 14;
        return -(((-v) - 1) >>> 14) - 1;
    endfunction

    function automatic pixel_t project_vertex(logic [23:0] vx, logic [23:0] vy,
                                              logic [23:0] vz, logic last);
        pixel_t p;
        longint tx, ty, tz, xr, zt, yr, zr, sx, sy, q;
        longint f;
        logic   clip;
        tx = longint'($signed(vx)) - longint'(cam_x);
        ty = longint'($signed(vy)) - longint'(cam_y);
        tz = longint'($signed(vz)) - longint'(cam_z);
        f  = longint'(focal);
        xr = floor_shift14(rot1_cos * tx - rot1_sin * tz);
        zt = floor_shift14(rot1_sin * tx + rot1_cos * tz);
        yr = floor_shift14(rot2_cos * ty - rot2_sin * zt);
        zr = floor_shift14(rot2_sin * ty + rot2_cos * zt);
        clip = 1'b0;
        sx = 0;
        sy = 0;
        if (zr > 8388607)
        begin
            p.depth_z = 24'h7fffff;
            clip = 1'b1;
        end
        else if (zr < -8388608)
        begin
            p.depth_z = 24'h800000;
            clip = 1'b1;
        end
        else
            p.depth_z = zr[23:0];
        p.behind = (zr <= 0);
        if (!p.behind)
        begin
            // SystemVerilog division truncates toward zero, as required.
            q = (xr * f + 400 * zr) / zr;
            if (q > 32767) begin sx = 32767; clip = 1'b1; end
            else if (q < -32768) begin sx = -32768; clip = 1'b1; end
            else sx = q;
            q = (yr * f + 300 * zr) / zr;
            if (q > 32767) begin sy = 32767; clip = 1'b1; end
            else if (q < -32768) begin sy = -32768; clip = 1'b1; end
            else sy = q;
        end
        p.screen_x = sx[15:0];
        p.screen_y = sy[15:0];
        p.clipped  = clip;
        p.last     = last;
        return p;
    endfunction

    task automatic write_reg(reg_index_t idx, logic [23:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_CAM_X:  cam_x    = value;
            REG_CAM_Y:  cam_y    = value;
            REG_CAM_Z:  cam_z    = value;
            REG_ZX_COS: rot1_cos = value[15:0];
            REG_ZX_SIN: rot1_sin = value[15:0];
            REG_ZY_COS: rot2_cos = value[15:0];
            REG_ZY_SIN: rot2_sin = value[15:0];
            REG_FOCAL:  focal    = value[15:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Waits for the pipeline to empty so registers can change safely.
    task automatic drain_pipeline();
        s_axis_tvalid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic send_vertex(logic [23:0] vx, logic [23:0] vy, logic [23:0] vz,
                               logic last, bit typed, pixel_t want);
        pixel_t p;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {vz, vy, vx};
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        p = project_vertex(vx, vy, vz, last);
        if (typed)
        begin
            if (p !== want)
            begin
                $error("typed row disagrees with prediction: %p vs %p", want, p);
                error_count++;
            end
        end
        pending_pixels.push_back(p);
        sent_count++;
    endtask

    // Output side: random back-pressure and field-by-field comparison.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                pixel_t want;
                if (pending_pixels.size() == 0)
                begin
                    $error("result transaction with nothing pending");
                    error_count++;
                end
                else
                begin
                    want = pending_pixels.pop_front();
                    recv_count++;
                    if (want.behind) behind_count++;
                    if (want.clipped) clip_count++;
                    if (m_axis_tdata[15:0] !== want.screen_x)
                    begin
                        $error("screen_x expected %0h got %0h", want.screen_x,
                               m_axis_tdata[15:0]);
                        error_count++;
                    end
                    if (m_axis_tdata[31:16] !== want.screen_y)
                    begin
                        $error("screen_y expected %0h got %0h", want.screen_y,
                               m_axis_tdata[31:16]);
                        error_count++;
                    end
                    if (m_axis_tdata[55:32] !== want.depth_z)
                    begin
                        $error("depth_z expected %0h got %0h", want.depth_z,
                               m_axis_tdata[55:32]);
                        error_count++;
                    end
                    if (m_axis_tdata[56] !== want.behind)
                    begin
                        $error("behind_camera expected %0b got %0b", want.behind,
                               m_axis_tdata[56]);
                        error_count++;
                    end
                    if (m_axis_tdata[57] !== want.clipped)
                    begin
                        $error("clipped expected %0b got %0b", want.clipped,
                               m_axis_tdata[57]);
                        error_count++;
                    end
                    if (m_axis_tlast !== want.last)
                    begin
                        $error("last_out expected %0b got %0b", want.last, m_axis_tlast);
                        error_count++;
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic logic [23:0] rand_coord();
        case ($urandom_range(5))
            0:       return 24'(24'h7fffff - $urandom_range(3));
            1:       return 24'(24'h800000 + $urandom_range(3));
            2, 3:    return 24'($signed($urandom_range(51200)) - 25600);
            default: return 24'($urandom());
        endcase
    endfunction

    task automatic random_camera();
        int ang;
        write_reg(REG_CAM_X, 24'($urandom_range(3) == 0 ? $urandom() :
                                 $urandom_range(2048) - 1024));
        write_reg(REG_CAM_Y, 24'($urandom_range(3) == 0 ? $urandom() :
                                 $urandom_range(2048) - 1024));
        write_reg(REG_CAM_Z, 24'($urandom_range(3) == 0 ? $urandom() :
                                 $urandom_range(2048) - 4096));
        ang = $urandom_range(4);
        // Mostly plausible trig pairs; sometimes raw values outside the unit range.
        write_reg(REG_ZX_COS, 24'(ang == 0 ? $urandom() : $urandom_range(32768) - 16384));
        write_reg(REG_ZX_SIN, 24'(ang == 0 ? $urandom() : $urandom_range(32768) - 16384));
        write_reg(REG_ZY_COS, 24'(ang == 1 ? $urandom() : $urandom_range(32768) - 16384));
        write_reg(REG_ZY_SIN, 24'(ang == 1 ? $urandom() : $urandom_range(32768) - 16384));
        case ($urandom_range(3))
            0:       write_reg(REG_FOCAL, 24'd0);
            1:       write_reg(REG_FOCAL, 24'hffff);
            default: write_reg(REG_FOCAL, 24'($urandom_range(4000, 1)));
        endcase
    endtask

    pixel_t none;

    initial
    begin
        int phase;
        none = '{default: '0};
        error_count = 0; sent_count = 0; recv_count = 0;
        behind_count = 0; clip_count = 0;
        send_idle_pct = 0; recv_stall_pct = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0; cfg_index = REG_CAM_X; cfg_data = '0;
        s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tlast = 1'b0;
        cam_x = '0; cam_y = '0; cam_z = '0;
        rot1_cos = 16'sd16384; rot1_sin = '0; rot2_cos = 16'sd16384; rot2_sin = '0;
        focal = 16'd1000;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows at reset settings: identity rotation, focal 1000.
        directed_rows = '{
            '{24'h0, 24'h0, 24'h000100, 1'b0, 1'b1,
              '{16'd400, 16'd300, 24'h000100, 1'b0, 1'b0, 1'b0}},
            '{24'h0, 24'h0, 24'h0, 1'b1, 1'b1,
              '{16'd0, 16'd0, 24'h0, 1'b1, 1'b0, 1'b1}},
            '{24'h0, 24'h0, 24'hffff00, 1'b0, 1'b1,
              '{16'd0, 16'd0, 24'hffff00, 1'b1, 1'b0, 1'b0}},
            '{24'h7fffff, 24'h0, 24'h000001, 1'b0, 1'b1,
              '{16'h7fff, 16'd300, 24'h000001, 1'b0, 1'b1, 1'b0}},
            '{24'h800000, 24'h800000, 24'h000001, 1'b1, 1'b1,
              '{16'h8000, 16'h8000, 24'h000001, 1'b0, 1'b1, 1'b1}},
            '{24'h7fffff, 24'h7fffff, 24'h7fffff, 1'b0, 1'b0, none},
            '{24'h800000, 24'h7fffff, 24'h800000, 1'b0, 1'b1,
              '{16'd0, 16'd0, 24'h800000, 1'b1, 1'b0, 1'b0}},
            '{24'h001000, 24'hfff000, 24'h002000, 1'b0, 1'b0, none},
            '{24'h555555, 24'haaaaaa, 24'h555555, 1'b1, 1'b0, none},
            '{24'haaaaaa, 24'h555555, 24'h2aaaaa, 1'b0, 1'b0, none}
        };
        foreach (directed_rows[i])
            send_vertex(directed_rows[i].vx, directed_rows[i].vy, directed_rows[i].vz,
                        directed_rows[i].last, directed_rows[i].typed, directed_rows[i].want);
        drain_pipeline();

        // Extreme camera and rotation settings with depth saturation, zero focal and maximum focal.
        write_reg(REG_CAM_Z, 24'h800000);
        write_reg(REG_ZX_COS, 24'h00c000);
        write_reg(REG_ZY_COS, 24'h007fff);
        write_reg(REG_FOCAL, 24'd0);
        send_vertex(24'h0, 24'h0, 24'h7fffff, 1'b1, 1'b0, none);
        send_vertex(24'h7fffff, 24'h800000, 24'h7fffff, 1'b0, 1'b0, none);
        drain_pipeline();
        write_reg(REG_ZX_COS, 24'hffc000);
        write_reg(REG_ZX_SIN, 24'h004000);
        write_reg(REG_ZY_SIN, 24'hffc000);
        write_reg(REG_CAM_X, 24'h7fffff);
        write_reg(REG_CAM_Y, 24'h800000);
        write_reg(REG_FOCAL, 24'hffff);
        send_vertex(24'h800000, 24'h7fffff, 24'h800000, 1'b0, 1'b0, none);
        send_vertex(24'h123456, 24'h000100, 24'h7fffff, 1'b1, 1'b0, none);
        drain_pipeline();

        for (phase = 0; phase < 8; phase++)
        begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
                default: begin send_idle_pct = 38; recv_stall_pct = 38; end
            endcase
            random_camera();
            repeat (230)
                send_vertex(rand_coord(), rand_coord(), rand_coord(),
                            $urandom_range(7) == 0, 1'b0, none);
            if (phase == 3)
            begin
                // Hold the stream until every outstanding vertex has come back.
                s_axis_tvalid <= 1'b0;
                while (pending_pixels.size() != 0)
                    @(posedge clk);
            end
            drain_pipeline();
        end
        recv_stall_pct = 0;
        drain_pipeline();

        $display("Sent %0d and checked %0d vertices across %0d camera settings.",
                 sent_count, recv_count, 11);
        $display("Of those, %0d were behind the camera and %0d clipped.",
                 behind_count, clip_count);
        if (error_count == 0 && pending_pixels.size() == 0)
            $display("PASS vertex_view_transform_project");
        else
            $display("FAIL vertex_view_transform_project");
        $finish;
    end

endmodule
